/* rtl/core/gwsm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwsm_pkg
// Shared types and constants for the glob wildcard stream matcher.
// ----------------------------------------------------------------------------

package gwsm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LEN_W      = 6;
	localparam int BYTE_W     = 8;

	typedef logic [CFG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_PATTERN_LENGTH = 3'd0;
	localparam reg_idx_t REG_PATTERN_WORD0  = 3'd1;
	localparam reg_idx_t REG_PATTERN_WORD3  = 3'd4;

	localparam logic [BYTE_W-1:0] STAR_BYTE  = 8'h2A;
	localparam logic [BYTE_W-1:0] QMARK_BYTE = 8'h3F;
	localparam logic [BYTE_W-1:0] NUL_BYTE   = 8'h00;

	typedef struct packed {
		logic                  valid;
		reg_idx_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic rearm;
		logic load;
	} cell_ctl_t;

endpackage

/* rtl/core/gwsm_prefix_or.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwsm_prefix_or
// Log-depth carry-style prefix: out[j] = g[j] | (p[j] & out[j-1]).
// ----------------------------------------------------------------------------

module gwsm_prefix_or #(
	parameter int W = 33
) (
	input  logic [W-1:0] g,
	input  logic [W-1:0] p,
	output logic [W-1:0] y
);

	localparam int LEVELS = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0] g_lvl [LEVELS+1];
	logic [W-1:0] p_lvl [LEVELS+1];

	always_comb begin
		g_lvl[0] = g;
		p_lvl[0] = p;
		p_lvl[0][0] = 1'b0;
		for (int l = 0; l < LEVELS; l++) begin
			for (int j = 0; j < W; j++) begin
				if (j >= (1 << l)) begin
					g_lvl[l+1][j] = g_lvl[l][j] | (p_lvl[l][j] & g_lvl[l][j-(1<<l)]);
					p_lvl[l+1][j] = p_lvl[l][j] & p_lvl[l][j-(1<<l)];
				end else begin
					g_lvl[l+1][j] = g_lvl[l][j];
					p_lvl[l+1][j] = p_lvl[l][j];
				end
			end
		end
	end

	assign y = g_lvl[LEVELS];

endmodule

/* rtl/core/gwsm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwsm_cell
// One pattern position: holds its pattern byte and its reachable bit, and
// hands an advance to the next position when the line byte matches.
// ----------------------------------------------------------------------------

module gwsm_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gwsm_pkg::cfg_wr_t             cfg,
	input  gwsm_pkg::cell_ctl_t           ctl,
	input  logic [gwsm_pkg::BYTE_W-1:0]   line_byte,
	input  logic                          start_bit,
	input  logic                          active,
	input  logic                          adv_in,
	input  logic                          closed_bit,
	output logic                          adv_out,
	output logic                          raw_next,
	output logic                          star_act,
	output logic                          zero_flag,
	output logic                          cur_bit
);

	localparam int WORD = CELL_IDX / 8;
	localparam int LANE = CELL_IDX % 8;

	logic [gwsm_pkg::BYTE_W-1:0] pat_q;
	logic                        reach_q;
	logic                        is_star;
	logic                        hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= gwsm_pkg::NUL_BYTE;
		end else if (cfg.valid &&
		             cfg.index == gwsm_pkg::CFG_IDX_W'(gwsm_pkg::REG_PATTERN_WORD0 + WORD)) begin
			pat_q <= cfg.data[LANE*8 +: 8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= 1'b0;
		end else if (ctl.load) begin
			reach_q <= closed_bit;
		end
	end

	assign is_star   = (pat_q == gwsm_pkg::STAR_BYTE);
	assign hit       = (pat_q == gwsm_pkg::QMARK_BYTE) || (pat_q == line_byte);
	assign zero_flag = (pat_q == gwsm_pkg::NUL_BYTE);
	assign cur_bit   = ctl.rearm ? start_bit : reach_q;
	assign star_act  = is_star & active;
	assign adv_out   = cur_bit & active & ~is_star & hit;
	assign raw_next  = (cur_bit & star_act) | adv_in;

endmodule

/* rtl/core/glob_wildcard_stream_matcher.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_stream_matcher
// Matches a byte-streamed line against one glob pattern ('*', '?') with a
// chain of position cells holding the NFA reachable set.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------
//  byte in  | byte_valid/byte_stall     | line_byte, end_of_line
//  result   | result_valid/result_stall | matched
//  config   | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
//  One request per cycle while byte_stall is low; the whole NFA step and star
//  closure happen in the cycle the byte is taken, which also registers the result.
//  byte_stall rises only while a result waits and result_stall is high.
//  Reset clears the pattern and arms the line; cfg_ready is always high.
// ----------------------------------------------------------------------------

module glob_wildcard_stream_matcher #(
	parameter int PATTERN_MAX = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              byte_valid,
	output logic                              byte_stall,
	input  logic [gwsm_pkg::BYTE_W-1:0]       line_byte,
	input  logic                              end_of_line,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              matched,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [gwsm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gwsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int N = PATTERN_MAX;

	gwsm_pkg::cfg_wr_t   cfg;
	gwsm_pkg::cell_ctl_t ctl;

	logic [gwsm_pkg::LEN_W-1:0] len_q;
	logic                       rearm_q;
	logic                       reach_end_q;
	logic                       result_valid_q;
	logic                       matched_q;

	logic         byte_acc;
	logic         byte_nz;
	logic         cfg_hit;
	logic [N-1:0] star_act;
	logic [N-1:0] adv;
	logic [N-1:0] zero_flag;
	logic [N-1:0] dead_in;
	logic [N-1:0] dead;
	logic [N-1:0] act;
	logic [N:0]   raw;
	logic [N:0]   cur;
	logic [N:0]   start;
	logic [N:0]   closed;
	logic [N:0]   sel_vec;
	logic [N:0]   end_vec;
	logic         matched_next;

	assign cfg_ready  = 1'b1;
	assign cfg.valid  = cfg_valid & cfg_ready;
	assign cfg.index  = cfg_index;
	assign cfg.data   = cfg_data;

	// writes to unused indexes leave the line alone
	assign cfg_hit    = cfg.valid && (cfg.index <= gwsm_pkg::REG_PATTERN_WORD3);

	assign byte_stall = result_valid_q & result_stall;
	assign byte_acc   = byte_valid & ~byte_stall;
	assign byte_nz    = (line_byte != gwsm_pkg::NUL_BYTE);

	assign ctl.rearm  = rearm_q;
	assign ctl.load   = byte_acc & byte_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg.valid && cfg.index == gwsm_pkg::REG_PATTERN_LENGTH) begin
			len_q <= cfg_data[gwsm_pkg::LEN_W-1:0];
		end
	end

	// pattern positions in use: below length and before the first NUL
	always_comb begin
		for (int i = 0; i < N; i++) begin
			dead_in[i] = zero_flag[i] | ~(len_q > gwsm_pkg::LEN_W'(i));
		end
	end

	gwsm_prefix_or #(.W(N)) u_active (
		.g (dead_in),
		.p ({N{1'b1}}),
		.y (dead)
	);

	assign act = ~dead;

	gwsm_prefix_or #(.W(N + 1)) u_start (
		.g ({{N{1'b0}}, 1'b1}),
		.p ({star_act, 1'b0}),
		.y (start)
	);

	gwsm_prefix_or #(.W(N + 1)) u_closure (
		.g (raw),
		.p ({star_act, 1'b0}),
		.y (closed)
	);

	for (genvar i = 0; i < N; i++) begin : g_cell
		gwsm_cell #(.CELL_IDX(i)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cfg        (cfg),
			.ctl        (ctl),
			.line_byte  (line_byte),
			.start_bit  (start[i]),
			.active     (act[i]),
			.adv_in     ((i == 0) ? 1'b0 : adv[(i == 0) ? 0 : i-1]),
			.closed_bit (closed[i]),
			.adv_out    (adv[i]),
			.raw_next   (raw[i]),
			.star_act   (star_act[i]),
			.zero_flag  (zero_flag[i]),
			.cur_bit    (cur[i])
		);
	end

	// final position, past the last pattern byte
	assign raw[N] = adv[N-1];
	assign cur[N] = rearm_q ? start[N] : reach_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_end_q <= 1'b0;
		end else if (ctl.load) begin
			reach_end_q <= closed[N];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rearm_q <= 1'b1;
		end else if (cfg_hit || (byte_acc && end_of_line)) begin
			rearm_q <= 1'b1;
		end else if (ctl.load) begin
			rearm_q <= 1'b0;
		end
	end

	// one-hot pick of the position equal to the effective length
	always_comb begin
		for (int j = 0; j <= N; j++) begin
			end_vec[j] = ((j == 0) ? 1'b1 : act[(j == 0) ? 0 : j-1]) &
			             ((j == N) ? 1'b1 : ~act[(j == N) ? 0 : j]);
		end
	end

	assign sel_vec      = byte_nz ? closed : cur;
	assign matched_next = |(sel_vec & end_vec);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (byte_acc && end_of_line) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_acc && end_of_line) begin
			matched_q <= matched_next;
		end
	end

	assign result_valid = result_valid_q;
	assign matched      = matched_q;

endmodule

/* sim/glob_wildcard_stream_matcher_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glob_wildcard_stream_matcher_tb
// Streams lines into the matcher under several glob patterns and checks every
// match flag against a bit-vector NFA model of the pattern kept in the bench.
// Pattern registers are rewritten between phases, and both sides idle at random.
// ----------------------------------------------------------------------------

module glob_wildcard_stream_matcher_tb;

	localparam int                 PAT_MAX      = 32;
	localparam int                 N_WORDS      = 4;
	localparam gwsm_pkg::reg_idx_t REG_LAST     =
		gwsm_pkg::REG_PATTERN_WORD0 + gwsm_pkg::reg_idx_t'(N_WORDS - 1);
	localparam int                 ITEMS_WANTED = 950;
	localparam int                 HOLD_CYCLES  = 300;
	localparam int                 STALL_LIMIT  = 3000;
	localparam int                 DRAIN_CYCLES = 8;
	localparam logic [7:0]         CHAR_A       = 8'h61;

	class glob_line_checker;
		logic [gwsm_pkg::LEN_W-1:0]      len_reg;
		logic [gwsm_pkg::CFG_DATA_W-1:0] words [N_WORDS];
		logic [PAT_MAX:0]                reach;
		bit                              expected_matches [$];
		int                              errors;

		function new();
			len_reg = '0;
			foreach (words[w]) words[w] = '0;
			errors = 0;
			rearm();
		endfunction

		function logic [7:0] pat_byte(int k);
			return words[k / 8][(k % 8) * 8 +: 8];
		endfunction

		// pattern stops at the length register or the first NUL, whichever first
		function int eff_len();
			int n;
			n = int'(len_reg);
			if (n > PAT_MAX) n = PAT_MAX;
			for (int k = 0; k < n; k++)
				if (pat_byte(k) == gwsm_pkg::NUL_BYTE) return k;
			return n;
		endfunction

		function logic [PAT_MAX:0] star_closure(logic [PAT_MAX:0] s, int n);
			for (int i = 0; i < n; i++)
				if (s[i] && pat_byte(i) == gwsm_pkg::STAR_BYTE) s[i + 1] = 1'b1;
			return s;
		endfunction

		function void rearm();
			reach = star_closure({{PAT_MAX{1'b0}}, 1'b1}, eff_len());
		endfunction

		function void write_reg(gwsm_pkg::reg_idx_t idx, logic [gwsm_pkg::CFG_DATA_W-1:0] d);
			if (idx == gwsm_pkg::REG_PATTERN_LENGTH) len_reg = d[gwsm_pkg::LEN_W-1:0];
			else if (idx <= REG_LAST) words[idx - gwsm_pkg::REG_PATTERN_WORD0] = d;
			else return;
			rearm();
		endfunction

		function void note_byte(logic [7:0] c, logic eol);
			int               n;
			logic [PAT_MAX:0] nxt;
			logic [7:0]       p;
			n = eff_len();
			if (c != gwsm_pkg::NUL_BYTE) begin
				nxt = '0;
				for (int i = 0; i < n; i++) begin
					if (reach[i]) begin
						p = pat_byte(i);
						if (p == gwsm_pkg::STAR_BYTE) nxt[i] = 1'b1;
						else if (p == gwsm_pkg::QMARK_BYTE || p == c) nxt[i + 1] = 1'b1;
					end
				end
				reach = star_closure(nxt, n);
			end
			if (eol) begin
				expected_matches.push_back(reach[n]);
				rearm();
			end
		endfunction

		function void check_match(logic m);
			bit e;
			if (expected_matches.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result: matched=%0b, no line pending", m);
			end else begin
				e = expected_matches.pop_front();
				if (m !== e) begin
					errors++;
					if (errors <= 10) $display("matched mismatch: expected %0b, got %0b", e, m);
				end
			end
		endfunction

		function int pending();
			return expected_matches.size();
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            byte_valid;
	logic                            byte_stall;
	logic [gwsm_pkg::BYTE_W-1:0]     line_byte;
	logic                            end_of_line;
	logic                            result_valid;
	logic                            result_stall;
	logic                            matched;
	logic                            cfg_valid;
	logic                            cfg_ready;
	gwsm_pkg::reg_idx_t              cfg_index;
	logic [gwsm_pkg::CFG_DATA_W-1:0] cfg_data;

	glob_line_checker match_model;
	logic [7:0]       pat_buf [PAT_MAX];
	bit               tx_idle;
	bit               rx_idle;
	bit               hold_req;
	int               sent;
	int               quiet_cycles;

	glob_wildcard_stream_matcher #(.PATTERN_MAX(PAT_MAX)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.line_byte   (line_byte),
		.end_of_line (end_of_line),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.matched     (matched),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] rand_line_char();
		if ($urandom_range(0, 9) != 0) return CHAR_A + 8'($urandom_range(0, 2));
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] rand_pattern_byte();
		int r;
		r = $urandom_range(0, 39);
		if (r == 0) return gwsm_pkg::NUL_BYTE;
		if (r <= 8) return gwsm_pkg::STAR_BYTE;
		if (r <= 12) return gwsm_pkg::QMARK_BYTE;
		if (r <= 36) return CHAR_A + 8'($urandom_range(0, 2));
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [gwsm_pkg::CFG_DATA_W-1:0] pack_word(int w);
		logic [gwsm_pkg::CFG_DATA_W-1:0] d;
		for (int b = 0; b < 8; b++) d[b * 8 +: 8] = pat_buf[w * 8 + b];
		return d;
	endfunction

	function automatic void fill_text(string s);
		foreach (pat_buf[k]) pat_buf[k] = (k < s.len()) ? s[k] : gwsm_pkg::NUL_BYTE;
	endfunction

	// entered and left at a falling edge
	task automatic send_item(logic [7:0] b, logic eol);
		int gap;
		gap = tx_idle ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			byte_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_valid  = 1'b1;
		line_byte   = b;
		end_of_line = eol;
		do @(posedge clk); while (byte_stall);
		match_model.note_byte(b, eol);
		if (b != gwsm_pkg::NUL_BYTE || eol) sent++;
		@(negedge clk);
	endtask

	task automatic send_text(string s);
		if (s.len() == 0) send_item(gwsm_pkg::NUL_BYTE, 1'b1);
		else for (int k = 0; k < s.len(); k++) send_item(s[k], k == s.len() - 1);
	endtask

	task automatic cfg_write(gwsm_pkg::reg_idx_t idx, logic [gwsm_pkg::CFG_DATA_W-1:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		do @(posedge clk); while (!cfg_ready);
		match_model.write_reg(idx, d);
		@(negedge clk);
	endtask

	// all five pattern registers, starting from a rotating position
	task automatic write_pattern(int len_val, int first);
		logic [gwsm_pkg::CFG_DATA_W-1:0] d;
		int                              j;
		for (int s = 0; s <= N_WORDS; s++) begin
			j = (first + s) % (N_WORDS + 1);
			if (j == 0) begin
				d = {$urandom, $urandom};
				d[gwsm_pkg::LEN_W-1:0] = gwsm_pkg::LEN_W'(len_val);
				cfg_write(gwsm_pkg::REG_PATTERN_LENGTH, d);
			end else begin
				cfg_write(gwsm_pkg::REG_PATTERN_WORD0 + gwsm_pkg::reg_idx_t'(j - 1),
				          pack_word(j - 1));
			end
		end
		cfg_valid = 1'b0;
	endtask

	task automatic settle();
		byte_valid = 1'b0;
		while (match_model.pending() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic random_config();
		int len_val;
		foreach (pat_buf[k]) pat_buf[k] = rand_pattern_byte();
		case ($urandom_range(0, 9))
			0: begin
				len_val = 0;
			end
			1: begin
				len_val = PAT_MAX;
			end
			2: begin
				len_val = $urandom_range(PAT_MAX + 1, 63);
			end
			3: begin
				len_val = $urandom_range(9, PAT_MAX - 1);
			end
			default: begin
				len_val = $urandom_range(1, 8);
			end
		endcase
		if ($urandom_range(0, 3) == 0)
			cfg_write(gwsm_pkg::reg_idx_t'(REG_LAST + $urandom_range(1, 3)),
			          {$urandom, $urandom});
		write_pattern(len_val, $urandom_range(0, N_WORDS));
	endtask

	// mostly lines built from the pattern, sometimes lightly damaged
	task automatic send_random_line();
		logic [7:0] text [$];
		logic [7:0] p;
		int         n;
		int         r;
		bit         zero_end;
		n = match_model.eff_len();
		zero_end = ($urandom_range(0, 7) == 0);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(0, 8)) text.push_back(rand_line_char());
		end else begin
			for (int k = 0; k < n; k++) begin
				p = match_model.pat_byte(k);
				if (p == gwsm_pkg::STAR_BYTE)
					repeat ($urandom_range(0, 3)) text.push_back(rand_line_char());
				else if (p == gwsm_pkg::QMARK_BYTE) text.push_back(rand_line_char());
				else text.push_back(p);
			end
			r = $urandom_range(0, 5);
			if (r == 0 && text.size() > 0)
				text[$urandom_range(0, text.size() - 1)] = rand_line_char();
			else if (r == 1 && text.size() > 0)
				text.delete($urandom_range(0, text.size() - 1));
			else if (r == 2)
				text.insert($urandom_range(0, text.size()), rand_line_char());
		end
		if (text.size() == 0) begin
			send_item(gwsm_pkg::NUL_BYTE, 1'b1);
		end else begin
			for (int k = 0; k < text.size(); k++) begin
				if ($urandom_range(0, 19) == 0) send_item(gwsm_pkg::NUL_BYTE, 1'b0);
				send_item(text[k], (k == text.size() - 1) && !zero_end);
			end
			if (zero_end) send_item(gwsm_pkg::NUL_BYTE, 1'b1);
		end
	endtask

	// result side
	initial begin
		int k;
		result_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				result_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			k = rx_idle ? $urandom_range(0, 14) : 0;
			if (k > 0) begin
				result_stall = 1'b1;
				repeat (k) @(negedge clk);
			end
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			match_model.check_match(matched);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int  n_lines;
		bit  held;
		match_model  = new();
		arst_n       = 1'b0;
		byte_valid   = 1'b0;
		line_byte    = gwsm_pkg::NUL_BYTE;
		end_of_line  = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = gwsm_pkg::REG_PATTERN_LENGTH;
		cfg_data     = '0;
		tx_idle      = 1'b0;
		rx_idle      = 1'b0;
		hold_req     = 1'b0;
		sent         = 0;
		held         = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty pattern out of reset
		send_text("");
		send_text("a");
		send_item(gwsm_pkg::NUL_BYTE, 1'b0);

		settle();
		fill_text("a*?c*");
		write_pattern(5, 0);
		rx_idle = 1'b1;
		send_text("abc");
		send_text("ac");
		send_text("aXbc");
		send_item(8'h80, 1'b0);
		send_item(CHAR_A + 8'd2, 1'b1);

		// over-long length saturates, all stars
		settle();
		tx_idle = 1'b1;
		foreach (pat_buf[k]) pat_buf[k] = gwsm_pkg::STAR_BYTE;
		write_pattern(63, 2);
		send_text("x");
		send_text("");

		// NUL inside the pattern ends it early
		settle();
		fill_text("ab?cd?");
		pat_buf[2] = gwsm_pkg::NUL_BYTE;
		write_pattern(6, 4);
		send_text("ab");
		send_text("abc");

		// all-ones words, out-of-range indexes leave everything alone
		settle();
		foreach (pat_buf[k]) pat_buf[k] = 8'hFF;
		write_pattern(2, 1);
		for (int j = 1; j <= 3; j++)
			cfg_write(gwsm_pkg::reg_idx_t'(REG_LAST + j), {gwsm_pkg::CFG_DATA_W{1'b1}});
		cfg_valid = 1'b0;
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h7F, 1'b1);
		send_item(8'hFF, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(gwsm_pkg::NUL_BYTE, 1'b1);

		while (sent < ITEMS_WANTED) begin
			settle();
			tx_idle = ($urandom_range(0, 3) != 0);
			rx_idle = ($urandom_range(0, 3) != 0);
			random_config();
			if (!held && sent > ITEMS_WANTED / 3) begin
				// receiver holds off so the result register fills and input backs up
				held     = 1'b1;
				tx_idle  = 1'b0;
				hold_req = 1'b1;
				repeat (40) send_item(rand_line_char(), 1'b1);
			end
			n_lines = $urandom_range(4, 16);
			repeat (n_lines) send_random_line();
			// partial line, cut short by the next pattern write
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) send_item(rand_line_char(), 1'b0);
		end

		settle();
		if (match_model.errors == 0 && match_model.pending() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
